>>> rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and the vehicle box test for the point transform
// and crop block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int COORD_FRAC     = 10;
    localparam int COEF_WIDTH     = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int INTENSITY_W    = 8;
    localparam int ROW_W          = 3 * COEF_WIDTH;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = ROW_W;

    // point word: x, y, z, intensity from bit 0 up, padded to whole bytes
    localparam int POINT_BITS = 3 * COORD_WIDTH + INTENSITY_W;
    localparam int TDATA_W    = ((POINT_BITS + 7) / 8) * 8;

    localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SUM_W  = ACC_W - COEF_FRAC_BITS + 1;
    localparam int ROUND_HALF = 1 << (COEF_FRAC_BITS - 1);

    localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1 << COEF_FRAC_BITS);
    localparam logic [COEF_WIDTH-1:0] COEF_ZERO = '0;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // vehicle box: centre (0, 0.5, -1) m, half extents (5, 2, 2) m
    localparam int BOX_CX = 0;
    localparam int BOX_CY = 1 << (COORD_FRAC - 1);
    localparam int BOX_CZ = -(1 << COORD_FRAC);
    localparam int BOX_HX = 5 << COORD_FRAC;
    localparam int BOX_HY = 2 << COORD_FRAC;
    localparam int BOX_HZ = 2 << COORD_FRAC;

    localparam logic signed [COORD_WIDTH-1:0] BOX_X_LO = COORD_WIDTH'(BOX_CX - BOX_HX);
    localparam logic signed [COORD_WIDTH-1:0] BOX_X_HI = COORD_WIDTH'(BOX_CX + BOX_HX);
    localparam logic signed [COORD_WIDTH-1:0] BOX_Y_LO = COORD_WIDTH'(BOX_CY - BOX_HY);
    localparam logic signed [COORD_WIDTH-1:0] BOX_Y_HI = COORD_WIDTH'(BOX_CY + BOX_HY);
    localparam logic signed [COORD_WIDTH-1:0] BOX_Z_LO = COORD_WIDTH'(BOX_CZ - BOX_HZ);
    localparam logic signed [COORD_WIDTH-1:0] BOX_Z_HI = COORD_WIDTH'(BOX_CZ + BOX_HZ);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROT_ROW_X = 3'd0,
        REG_ROT_ROW_Y = 3'd1,
        REG_ROT_ROW_Z = 3'd2,
        REG_OFFSET_X  = 3'd3,
        REG_OFFSET_Y  = 3'd4,
        REG_OFFSET_Z  = 3'd5,
        REG_X_MIN     = 3'd6
    } ptc_reg_t;

    typedef struct packed {
        logic [ROW_W-1:0]              rot_row_x;
        logic [ROW_W-1:0]              rot_row_y;
        logic [ROW_W-1:0]              rot_row_z;
        logic signed [COORD_WIDTH-1:0] offset_x;
        logic signed [COORD_WIDTH-1:0] offset_y;
        logic signed [COORD_WIDTH-1:0] offset_z;
        logic signed [COORD_WIDTH-1:0] x_min;
    } ptc_cfg_t;

    typedef struct packed {
        logic                          source;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic [INTENSITY_W-1:0]        intensity;
    } ptc_point_t;

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        ptc_point_t            pt;
        prod_t [2:0][2:0]      prod;   // [row][column]
    } ptc_prod_t;

    function automatic logic in_box(input logic signed [COORD_WIDTH-1:0] x,
                                    input logic signed [COORD_WIDTH-1:0] y,
                                    input logic signed [COORD_WIDTH-1:0] z);
        logic ix;
        logic iy;
        logic iz;
        ix = (x >= BOX_X_LO) && (x <= BOX_X_HI);
        iy = (y >= BOX_Y_LO) && (y <= BOX_Y_HI);
        iz = (z >= BOX_Z_LO) && (z <= BOX_Z_HI);
        return ix && iy && iz;
    endfunction

endpackage

>>> rtl/ptc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ptc_cfg_regs
// Configuration register file: rotation rows, translation and x crop limit.
// ----------------------------------------------------------------------------
module ptc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [ptc_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]   wr_data,
    output ptc_pkg::ptc_cfg_t                cfg
);
    import ptc_pkg::*;

    ptc_cfg_t cfg_reg;
    ptc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (ptc_reg_t'(wr_index))
                REG_ROT_ROW_X: cfg_next.rot_row_x = wr_data[ROW_W-1:0];
                REG_ROT_ROW_Y: cfg_next.rot_row_y = wr_data[ROW_W-1:0];
                REG_ROT_ROW_Z: cfg_next.rot_row_z = wr_data[ROW_W-1:0];
                REG_OFFSET_X:  cfg_next.offset_x  = wr_data[COORD_WIDTH-1:0];
                REG_OFFSET_Y:  cfg_next.offset_y  = wr_data[COORD_WIDTH-1:0];
                REG_OFFSET_Z:  cfg_next.offset_z  = wr_data[COORD_WIDTH-1:0];
                REG_X_MIN:     cfg_next.x_min     = wr_data[COORD_WIDTH-1:0];
                default:       cfg_next = cfg_reg;   // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // identity rotation, no offset, x_min = 0
            cfg_reg.rot_row_x <= {COEF_ZERO, COEF_ZERO, COEF_ONE};
            cfg_reg.rot_row_y <= {COEF_ZERO, COEF_ONE, COEF_ZERO};
            cfg_reg.rot_row_z <= {COEF_ONE, COEF_ZERO, COEF_ZERO};
            cfg_reg.offset_x  <= '0;
            cfg_reg.offset_y  <= '0;
            cfg_reg.offset_z  <= '0;
            cfg_reg.x_min     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/ptc_rotate.sv
// ----------------------------------------------------------------------------
// ptc_rotate
// Product stage: nine coefficient-by-coordinate products, registered.
// ----------------------------------------------------------------------------
module ptc_rotate (
    input  logic                clk,
    input  logic                load,
    input  ptc_pkg::ptc_point_t pt,
    input  ptc_pkg::ptc_cfg_t   cfg,
    output ptc_pkg::ptc_prod_t  stage
);
    import ptc_pkg::*;

    ptc_prod_t stage_reg;
    ptc_prod_t stage_next;

    logic [ROW_W-1:0]              rows [3];
    logic signed [COORD_WIDTH-1:0] pos  [3];

    always_comb
    begin
        rows[0] = cfg.rot_row_x;
        rows[1] = cfg.rot_row_y;
        rows[2] = cfg.rot_row_z;
        pos[0]  = pt.x;
        pos[1]  = pt.y;
        pos[2]  = pt.z;
    end

    always_comb
    begin
        logic signed [COEF_WIDTH-1:0]  cf;
        logic signed [COORD_WIDTH-1:0] pv;
        stage_next.pt = pt;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cf = rows[r][c*COEF_WIDTH +: COEF_WIDTH];
                pv = pos[c];
                stage_next.prod[r][c] = cf * pv;   // full PROD_W signed product
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

>>> rtl/ptc_finish.sv
// ----------------------------------------------------------------------------
// ptc_finish
// Row sums, rounding, translation with saturation, source select and the
// vehicle box reject.
// ----------------------------------------------------------------------------
module ptc_finish (
    input  ptc_pkg::ptc_prod_t  stage,
    input  ptc_pkg::ptc_cfg_t   cfg,
    output ptc_pkg::ptc_point_t result,
    output logic                keep
);
    import ptc_pkg::*;

    function automatic logic signed [COORD_WIDTH-1:0] row_out(
        input logic signed [PROD_W-1:0]      p0,
        input logic signed [PROD_W-1:0]      p1,
        input logic signed [PROD_W-1:0]      p2,
        input logic signed [COORD_WIDTH-1:0] off);
        logic signed [ACC_W-1:0]       acc;
        logic signed [SUM_W-1:0]       sum;
        logic [SUM_W-COORD_WIDTH:0]    top;
        logic signed [COORD_WIDTH-1:0] res;
        acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + ACC_W'(ROUND_HALF);
        // floor shift of the rounded sum, then translate
        sum = SUM_W'($signed(acc[ACC_W-1:COEF_FRAC_BITS])) + SUM_W'(off);
        top = sum[SUM_W-1:COORD_WIDTH-1];
        if ((&top) || !(|top))
            res = sum[COORD_WIDTH-1:0];
        else if (sum[SUM_W-1])
            res = COORD_MIN;
        else
            res = COORD_MAX;
        return res;
    endfunction

    logic signed [COORD_WIDTH-1:0] tx;
    logic signed [COORD_WIDTH-1:0] ty;
    logic signed [COORD_WIDTH-1:0] tz;

    assign tx = row_out(stage.prod[0][0], stage.prod[0][1], stage.prod[0][2], cfg.offset_x);
    assign ty = row_out(stage.prod[1][0], stage.prod[1][1], stage.prod[1][2], cfg.offset_y);
    assign tz = row_out(stage.prod[2][0], stage.prod[2][1], stage.prod[2][2], cfg.offset_z);

    always_comb
    begin
        result = stage.pt;
        if (stage.pt.source)
        begin
            result.x = tx;
            result.y = ty;
            result.z = tz;
        end
    end

    assign keep = !in_box(result.x, result.y, result.z);

endmodule

>>> rtl/lidar_point_transform_crop.sv
// ----------------------------------------------------------------------------
// lidar_point_transform_crop
// Per-point lidar filter: drops invalid points, crops sensor 0 by x, applies
// the sensor 1 extrinsic (rotate, round, translate, saturate) and rejects
// points inside the vehicle box.
// ----------------------------------------------------------------------------
//
//  channel  | signals                 | word
//  ---------+-------------------------+-------------------------------------
//  s_axis   | tvalid tready tdata tuser| one point in
//  m_axis   | tvalid tready tdata tuser| one kept point out
//  cfg      | valid ready index data  | one register write, always ready
//
//  One point per clock sustained while m_axis_tready is high. A point goes
//  through the input register, product register (nine 16x24 multiplies),
//  then row sum / saturate / box test into the output register. A dropped
//  point leaves a bubble. A stall on m_axis_tready backs up stage by stage;
//  s_axis_tready falls only once all three registers are full. Reset clears
//  the valid bits and loads the identity extrinsic, zero offsets and x_min.
//
module lidar_point_transform_crop (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: pos_x, pos_y, pos_z, intensity (from bit 0 up, zero padded)
    input  logic [ptc_pkg::TDATA_W-1:0]       s_axis_tdata,
    // tuser: source, point_valid
    input  logic [1:0]                        s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: out_x, out_y, out_z, out_intensity (from bit 0 up, zero padded)
    output logic [ptc_pkg::TDATA_W-1:0]       m_axis_tdata,
    // tuser: out_source
    output logic [0:0]                        m_axis_tuser,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ptc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ptc_pkg::*;

    ptc_cfg_t   cfg;
    ptc_point_t in_pt;
    logic       in_point_valid;
    logic       in_accept;
    logic       in_keep;

    // pipeline valids and advance controls
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s2_valid_reg;
    logic       s2_valid_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       s1_adv;    // stage 1 contents may move into stage 2
    logic       s2_adv;    // stage 2 contents may move into the output

    ptc_point_t s1_pt_reg;
    ptc_prod_t  s2_stage;
    ptc_point_t fin_pt;
    logic       fin_keep;
    ptc_point_t out_pt_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    ptc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // ---------------- input unpack ----------------
    assign in_pt.source    = s_axis_tuser[0];
    assign in_point_valid  = s_axis_tuser[1];
    assign in_pt.x         = s_axis_tdata[COORD_WIDTH-1:0];
    assign in_pt.y         = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign in_pt.z         = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign in_pt.intensity = s_axis_tdata[POINT_BITS-1:3*COORD_WIDTH];

    // NaN points drop for either sensor; sensor 0 is cropped on x here
    assign in_keep = in_point_valid && (in_pt.source || (in_pt.x >= cfg.x_min));

    // ---------------- flow control ----------------
    assign s2_adv        = !out_valid_reg || m_axis_tready;
    assign s1_adv        = !s2_valid_reg || s2_adv;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_axis_tready)
            s1_valid_next = in_accept && in_keep;
        if (s1_adv)
            s2_valid_next = s1_valid_reg;
        if (s2_adv)
            out_valid_next = s2_valid_reg && fin_keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- stage 1: input register ----------------
    always_ff @(posedge clk)
    begin
        if (in_accept && in_keep)
        begin
            s1_pt_reg <= in_pt;
        end
    end

    // ---------------- stage 2: products ----------------
    ptc_rotate u_rotate (
        .clk   (clk),
        .load  (s1_adv && s1_valid_reg),
        .pt    (s1_pt_reg),
        .cfg   (cfg),
        .stage (s2_stage)
    );

    // ---------------- stage 3: sum, saturate, box ----------------
    ptc_finish u_finish (
        .stage  (s2_stage),
        .cfg    (cfg),
        .result (fin_pt),
        .keep   (fin_keep)
    );

    always_ff @(posedge clk)
    begin
        if (s2_adv && s2_valid_reg && fin_keep)
        begin
            out_pt_reg <= fin_pt;
        end
    end

    // ---------------- output ----------------
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_pt_reg.source;
    assign m_axis_tdata    = TDATA_W'({out_pt_reg.intensity, out_pt_reg.z,
                                       out_pt_reg.y, out_pt_reg.x});

    // ---------------- assertions ----------------
    // a delivered point never lies inside the vehicle box
    a_no_box_point: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !in_box(out_pt_reg.x, out_pt_reg.y, out_pt_reg.z))
        else $error("output point inside vehicle box");

    // a sensor 0 result respects the x crop
    a_x_crop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_pt_reg.source) |-> (out_pt_reg.x >= cfg.x_min))
        else $error("sensor 0 point below x_min delivered");

    // an empty input register always leaves the input open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty input register");

    // a blocked product stage keeps its point
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_adv) |=> (s2_valid_reg && $stable(s2_stage)))
        else $error("product stage lost a point under stall");

endmodule

>>> bench/point_check_pkg.sv
// ----------------------------------------------------------------------------
// point_check_pkg
// Expected-point predictor and scoreboard for the lidar transform/crop bench.
// Holds a private copy of the register file; every accepted input word is
// turned into zero or one expected output word, checked in order.
// ----------------------------------------------------------------------------
package point_check_pkg;

    localparam int CW        = ptc_pkg::COORD_WIDTH;
    localparam int DW        = ptc_pkg::TDATA_W;
    localparam int RW        = ptc_pkg::ROW_W;
    localparam int IW        = ptc_pkg::CFG_INDEX_W;
    localparam int FRAC      = ptc_pkg::COORD_FRAC;
    localparam int COEF_FRAC = ptc_pkg::COEF_FRAC_BITS;

    localparam longint COORD_HI = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint COORD_LO = -(longint'(1) <<< (CW - 1));

    // vehicle box: centre (0, 0.5, -1) m, half extents (5, 2, 2) m
    localparam int CEN_X  = 0;
    localparam int CEN_Y  = 1 << (FRAC - 1);
    localparam int CEN_Z  = -(1 << FRAC);
    localparam int HALF_X = 5 << FRAC;
    localparam int HALF_Y = 2 << FRAC;
    localparam int HALF_Z = 2 << FRAC;

    // first index past the register list; writes there are dropped
    localparam logic [IW-1:0] REG_NONE = IW'(7);

    typedef logic signed [CW-1:0] coord_t;

    localparam coord_t COORD_TOP    = {1'b0, {(CW - 1){1'b1}}};
    localparam coord_t COORD_BOTTOM = {1'b1, {(CW - 1){1'b0}}};

    typedef struct packed {
        logic          source;
        coord_t        x;
        coord_t        y;
        coord_t        z;
        logic [7:0]    intensity;
    } kept_point_t;

    // inclusive box bound on one axis (0 x, 1 y, 2 z)
    function automatic int box_edge(int axis, bit upper);
        int c;
        int h;
        case (axis)
            0:       begin c = CEN_X; h = HALF_X; end
            1:       begin c = CEN_Y; h = HALF_Y; end
            default: begin c = CEN_Z; h = HALF_Z; end
        endcase
        return upper ? c + h : c - h;
    endfunction

    class kept_point_scoreboard;
        logic [RW-1:0] rot_row [3];
        coord_t        offset [3];
        coord_t        x_min;
        kept_point_t   expected_points [$];
        int            errors;

        function new();
            for (int r = 0; r < 3; r++)
            begin
                rot_row[r] = '0;
                rot_row[r][16 * r +: 16] = 16'(1 << COEF_FRAC);
                offset[r] = '0;
            end
            x_min  = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [IW-1:0] index, logic [RW-1:0] value);
            case (index)
                ptc_pkg::REG_ROT_ROW_X: rot_row[0] = value;
                ptc_pkg::REG_ROT_ROW_Y: rot_row[1] = value;
                ptc_pkg::REG_ROT_ROW_Z: rot_row[2] = value;
                ptc_pkg::REG_OFFSET_X:  offset[0] = coord_t'(value[CW-1:0]);
                ptc_pkg::REG_OFFSET_Y:  offset[1] = coord_t'(value[CW-1:0]);
                ptc_pkg::REG_OFFSET_Z:  offset[2] = coord_t'(value[CW-1:0]);
                ptc_pkg::REG_X_MIN:     x_min = coord_t'(value[CW-1:0]);
                default: ;
            endcase
        endfunction

        // rotate, round half up, translate, saturate
        function coord_t transform_row(int r, coord_t x, coord_t y, coord_t z);
            longint acc;
            longint v;
            acc = longint'($signed(rot_row[r][15:0])) * longint'(x)
                + longint'($signed(rot_row[r][31:16])) * longint'(y)
                + longint'($signed(rot_row[r][47:32])) * longint'(z);
            v = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
            v = v + longint'(offset[r]);
            if (v > COORD_HI)
                v = COORD_HI;
            else if (v < COORD_LO)
                v = COORD_LO;
            return coord_t'(v);
        endfunction

        function bit inside_vehicle(coord_t x, coord_t y, coord_t z);
            return longint'(x) >= box_edge(0, 0) && longint'(x) <= box_edge(0, 1)
                && longint'(y) >= box_edge(1, 0) && longint'(y) <= box_edge(1, 1)
                && longint'(z) >= box_edge(2, 0) && longint'(z) <= box_edge(2, 1);
        endfunction

        function void note_point(logic [1:0] user, logic [DW-1:0] data);
            kept_point_t p;
            coord_t      in_x;
            coord_t      in_y;
            coord_t      in_z;
            in_x = coord_t'(data[CW-1:0]);
            in_y = coord_t'(data[2*CW-1:CW]);
            in_z = coord_t'(data[3*CW-1:2*CW]);
            if (!user[1])
                return;
            if (!user[0])
            begin
                if (in_x < x_min)
                    return;
                p.x = in_x;
                p.y = in_y;
                p.z = in_z;
            end
            else
            begin
                p.x = transform_row(0, in_x, in_y, in_z);
                p.y = transform_row(1, in_x, in_y, in_z);
                p.z = transform_row(2, in_x, in_y, in_z);
            end
            if (inside_vehicle(p.x, p.y, p.z))
                return;
            p.source    = user[0];
            p.intensity = data[3*CW +: 8];
            expected_points.insert(expected_points.size(), p);
        endfunction

        function void compare_field(string name, longint want, longint got, realtime at_ns);
            if (want != got)
            begin
                errors++;
                $display("%0.1f ns: %s expected %0d, actual %0d", at_ns, name, want, got);
            end
        endfunction

        function void check_point(logic [0:0] user, logic [DW-1:0] data, realtime at_ns);
            kept_point_t want;
            coord_t      got_x;
            coord_t      got_y;
            coord_t      got_z;
            got_x = coord_t'(data[CW-1:0]);
            got_y = coord_t'(data[2*CW-1:CW]);
            got_z = coord_t'(data[3*CW-1:2*CW]);
            if (expected_points.size() == 0)
            begin
                errors++;
                $display("%0.1f ns: point out with none expected, actual x %0d y %0d z %0d",
                         at_ns, got_x, got_y, got_z);
                return;
            end
            want = expected_points.pop_front();
            compare_field("source", longint'(want.source), longint'(user[0]), at_ns);
            compare_field("x", longint'(want.x), longint'(got_x), at_ns);
            compare_field("y", longint'(want.y), longint'(got_y), at_ns);
            compare_field("z", longint'(want.z), longint'(got_z), at_ns);
            compare_field("intensity", longint'(want.intensity),
                          longint'(data[3*CW +: 8]), at_ns);
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        function void report_leftover(realtime at_ns);
            if (expected_points.size() != 0)
            begin
                errors += expected_points.size();
                $display("%0.1f ns: %0d expected points never came out",
                         at_ns, expected_points.size());
            end
        endfunction
    endclass

endpackage

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Bench for lidar_point_transform_crop: drives point words and register
// writes, predicts each kept point and checks the output stream in order.
// Random gaps on both stream sides, one long output stall, one drain pause.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import point_check_pkg::*;

    // nothing accepted for this many cycles ends the run; longest legal quiet
    // stretch is the long output stall plus a few short bursts
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    // pipeline is three deep; dropped points may still be in flight after the
    // last expected point leaves, so wait a bit before touching registers
    localparam int SETTLE         = 8;
    localparam int PHASES         = 9;
    localparam int PHASE_WORDS    = 220;

    typedef enum int {
        SET_ROTATION,   // signed axis permutation near unit scale, small offsets
        SET_RANDOM,     // every coefficient and offset random
        SET_HIGH,       // all coefficients and offsets at positive extreme
        SET_LOW,        // all coefficients and offsets at negative extreme
        SET_BLIND       // zero matrix, sensor 1 folded onto box centre
    } setting_kind_t;

    setting_kind_t phase_plan [PHASES] = '{SET_ROTATION, SET_RANDOM, SET_HIGH,
                                           SET_ROTATION, SET_LOW, SET_BLIND,
                                           SET_RANDOM, SET_ROTATION, SET_ROTATION};

    logic          clk            = 1'b0;
    logic          rst_n          = 1'b0;

    logic          s_axis_tvalid  = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata   = '0;     // pos_x, pos_y, pos_z, intensity
    logic [1:0]    s_axis_tuser   = '0;     // source, point_valid

    logic          m_axis_tvalid;
    logic          m_axis_tready  = 1'b0;
    logic [DW-1:0] m_axis_tdata;            // out_x, out_y, out_z, out_intensity
    logic [0:0]    m_axis_tuser;            // out_source

    logic          cfg_valid      = 1'b0;
    logic          cfg_ready;
    logic [IW-1:0] cfg_index      = '0;
    logic [RW-1:0] cfg_data       = '0;

    kept_point_scoreboard sb = new();

    bit tx_idling     = 1'b0;
    bit rx_idling     = 1'b0;
    bit long_hold_req = 1'b0;
    int quiet_cycles  = 0;

    lidar_point_transform_crop DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor: every handshake is seen at the rising edge, before the block's
    // registers move. Output is checked before the input word of the same
    // edge is noted, so a stray output can never match a brand-new point.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_point(m_axis_tuser, m_axis_tdata, $realtime);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_point(s_axis_tuser, s_axis_tdata);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog: a hung handshake ends the run as a failure
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: random stall bursts while rx_idling is set, plus one long
    // hold on request. One assignment to tready per falling edge.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                if (long_hold_req)
                begin
                    stall_left    = LONG_HOLD;
                    long_hold_req = 1'b0;
                end
                else if (rx_idling && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 18);
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Input side: entered at a falling edge, returns at the falling edge after
    // the word was taken. tvalid stays high between back-to-back words.
    task automatic send_point(input logic src, input logic vld, input coord_t x,
                              input coord_t y, input coord_t z, input logic [7:0] inten);
        if (tx_idling && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'({inten, z, y, x});
        s_axis_tuser  <= {vld, src};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // caller lowers cfg_valid once the whole batch is written
    task automatic cfg_write(input logic [IW-1:0] index, input logic [RW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // coordinate register word; upper bits are junk the block must ignore
    function automatic logic [RW-1:0] coord_word(coord_t v);
        logic [RW-1:0] w;
        w = RW'({$urandom, $urandom});
        w[CW-1:0] = v;
        return w;
    endfunction

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic program_setting(input setting_kind_t kind);
        logic [RW-1:0] row [3];
        coord_t        off [3];
        coord_t        xmin;
        int            shift;
        int            sgn;
        shift = $urandom_range(0, 2);
        xmin  = coord_t'(int'($urandom_range(0, 16384)) - 8192);
        for (int r = 0; r < 3; r++)
        begin
            case (kind)
                SET_ROTATION:
                begin
                    sgn    = $urandom_range(0, 1) ? 1 : -1;
                    row[r] = '0;
                    row[r][16 * ((r + shift) % 3) +: 16] =
                        16'(sgn * (1 << COEF_FRAC) + int'($urandom_range(0, 64)) - 32);
                    off[r] = coord_t'(int'($urandom_range(0, 16384)) - 8192);
                end
                SET_RANDOM:
                begin
                    row[r] = RW'({$urandom, $urandom});
                    off[r] = coord_t'($urandom);
                    xmin   = coord_t'($urandom);
                end
                SET_HIGH:
                begin
                    row[r] = {3{16'h7FFF}};
                    off[r] = COORD_TOP;
                    xmin   = COORD_BOTTOM;
                end
                SET_LOW:
                begin
                    row[r] = {3{16'h8000}};
                    off[r] = COORD_BOTTOM;
                    xmin   = COORD_TOP;
                end
                default:
                begin
                    row[r] = '0;
                    off[r] = coord_t'(r == 0 ? CEN_X : (r == 1 ? CEN_Y : CEN_Z));
                end
            endcase
        end
        cfg_write(ptc_pkg::REG_ROT_ROW_X, row[0]);
        cfg_write(ptc_pkg::REG_ROT_ROW_Y, row[1]);
        cfg_write(ptc_pkg::REG_ROT_ROW_Z, row[2]);
        cfg_write(ptc_pkg::REG_OFFSET_X, coord_word(off[0]));
        cfg_write(ptc_pkg::REG_OFFSET_Y, coord_word(off[1]));
        cfg_write(ptc_pkg::REG_OFFSET_Z, coord_word(off[2]));
        cfg_write(ptc_pkg::REG_X_MIN, coord_word(xmin));
        if ($urandom_range(0, 1))
            cfg_write(REG_NONE, RW'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
    endtask

    // mode: 0 full range, 1 box edge +-1, 2 around the box,
    //       3 range extremes, zero and -1, 4 a few tens of metres
    function automatic coord_t pick_coord(int axis, int mode);
        int lo;
        int hi;
        lo = box_edge(axis, 0);
        hi = box_edge(axis, 1);
        case (mode)
            0: return coord_t'($urandom);
            1:
                case ($urandom_range(0, 5))
                    0:       return coord_t'(lo - 1);
                    1:       return coord_t'(lo);
                    2:       return coord_t'(lo + 1);
                    3:       return coord_t'(hi - 1);
                    4:       return coord_t'(hi);
                    default: return coord_t'(hi + 1);
                endcase
            2: return coord_t'(lo - 256 + int'($urandom_range(0, hi - lo + 512)));
            3:
                case ($urandom_range(0, 3))
                    0:       return COORD_BOTTOM;
                    1:       return COORD_TOP;
                    2:       return coord_t'(0);
                    default: return coord_t'(-1);
                endcase
            default: return coord_t'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    task automatic send_random_point();
        int     pick;
        int     mode;
        logic   src;
        coord_t x;
        pick = $urandom_range(0, 9);
        mode = pick < 2 ? 0 : (pick < 5 ? 1 : (pick < 7 ? 2 : (pick < 8 ? 3 : 4)));
        src  = 1'($urandom);
        x    = pick_coord(0, mode);
        // sensor 0 crop edge
        if (!src && $urandom_range(0, 7) == 0)
            x = sb.x_min + coord_t'(int'($urandom_range(0, 4)) - 2);
        send_point(src, $urandom_range(0, 9) != 0, x, pick_coord(1, mode),
                   pick_coord(2, mode), 8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        bit saved_idling;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: identity extrinsic, x_min 0
        send_point(1'b0, 1'b1, coord_t'(0), COORD_TOP, coord_t'(0), 8'h01);    // x at x_min: kept
        send_point(1'b0, 1'b1, coord_t'(-1), COORD_TOP, coord_t'(0), 8'h02);   // below x_min
        send_point(1'b0, 1'b1, COORD_TOP, COORD_TOP, COORD_TOP, 8'hFF);
        send_point(1'b0, 1'b1, COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 8'h00);
        send_point(1'b0, 1'b0, COORD_TOP, COORD_TOP, COORD_TOP, 8'hAA);        // invalid
        send_point(1'b1, 1'b0, COORD_TOP, COORD_TOP, COORD_TOP, 8'h55);        // invalid
        send_point(1'b1, 1'b1, COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 8'h00);
        send_point(1'b1, 1'b1, COORD_TOP, COORD_TOP, COORD_TOP, 8'hFF);
        // box corners, inclusive on both ends
        send_point(1'b0, 1'b1, coord_t'(box_edge(0, 1)), coord_t'(box_edge(1, 1)),
                   coord_t'(box_edge(2, 1)), 8'h10);
        send_point(1'b0, 1'b1, coord_t'(box_edge(0, 1) + 1), coord_t'(box_edge(1, 1)),
                   coord_t'(box_edge(2, 1)), 8'h11);
        send_point(1'b1, 1'b1, coord_t'(box_edge(0, 0)), coord_t'(box_edge(1, 0)),
                   coord_t'(box_edge(2, 0)), 8'h12);
        send_point(1'b1, 1'b1, coord_t'(box_edge(0, 0)), coord_t'(box_edge(1, 0) - 1),
                   coord_t'(box_edge(2, 0)), 8'h13);
        send_point(1'b1, 1'b1, coord_t'(0), coord_t'(0), coord_t'(box_edge(2, 0) - 1), 8'h14);
        send_point(1'b1, 1'b1, coord_t'(0), coord_t'(box_edge(1, 1) + 1), coord_t'(0), 8'h15);
        send_point(1'b1, 1'b1, coord_t'(0), coord_t'(0), coord_t'(box_edge(2, 1) + 1), 8'h16);
        send_point(1'b0, 1'b1, coord_t'(0), coord_t'(0), coord_t'(0), 8'h17);  // inside box
        wait_until_drained();

        // half-scale x row shows the round-half-up ties; y and z rows and
        // offsets sit at the extremes to push the sum into saturation
        cfg_write(ptc_pkg::REG_ROT_ROW_X, RW'(1 << (COEF_FRAC - 1)));
        cfg_write(ptc_pkg::REG_ROT_ROW_Y, {3{16'h7FFF}});
        cfg_write(ptc_pkg::REG_ROT_ROW_Z, {3{16'h8000}});
        cfg_write(ptc_pkg::REG_OFFSET_X, coord_word(coord_t'(0)));
        cfg_write(ptc_pkg::REG_OFFSET_Y, coord_word(COORD_TOP));
        cfg_write(ptc_pkg::REG_OFFSET_Z, coord_word(COORD_BOTTOM));
        cfg_write(ptc_pkg::REG_X_MIN, coord_word(coord_t'(-100)));
        cfg_valid <= 1'b0;
        send_point(1'b1, 1'b1, coord_t'(1), coord_t'(4000), coord_t'(0), 8'h20);
        send_point(1'b1, 1'b1, coord_t'(-1), coord_t'(4000), coord_t'(0), 8'h21);
        send_point(1'b1, 1'b1, coord_t'(3), coord_t'(-4000), coord_t'(0), 8'h22);
        send_point(1'b1, 1'b1, coord_t'(-3), coord_t'(-4000), coord_t'(0), 8'h23);
        send_point(1'b1, 1'b1, COORD_TOP, COORD_TOP, COORD_TOP, 8'h24);
        send_point(1'b1, 1'b1, COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 8'h25);
        send_point(1'b0, 1'b1, coord_t'(-100), COORD_TOP, coord_t'(0), 8'h26);
        send_point(1'b0, 1'b1, coord_t'(-101), COORD_TOP, coord_t'(0), 8'h27);
        wait_until_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            program_setting(phase_plan[p]);
            // final phase runs flat out on both sides
            tx_idling = (p != PHASES - 1);
            rx_idling = (p != PHASES - 1);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (p == 1 && i == PHASE_WORDS / 2)
                begin
                    // long output stall while input keeps coming: sensor 0 at
                    // top x is always kept, so the pipeline fills and backs up
                    long_hold_req = 1'b1;
                    saved_idling  = tx_idling;
                    tx_idling     = 1'b0;
                    repeat (40)
                        send_point(1'b0, 1'b1, COORD_TOP, coord_t'($urandom),
                                   coord_t'($urandom), 8'($urandom));
                    tx_idling = saved_idling;
                end
                if (p == 3 && i == PHASE_WORDS / 2)
                    wait_until_drained();
                send_random_point();
            end
            wait_until_drained();
        end

        sb.report_leftover($realtime);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
